>>> hw/rtl/umpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unsorted max-priority table: shared definitions
// Types, codes and widths used by the table controller, its memories and the
// top level.
// ----------------------------------------------------------------------------
package umpt_pkg;

    // Fixed field widths of the item interface.
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int FUNC_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 64;

    // Operation codes; the eighth code is unused and does nothing.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_EXTRACT   = 3'd1,
        FUNC_PEEK      = 3'd2,
        FUNC_FIND      = 3'd3,
        FUNC_SET_KEY   = 3'd4,
        FUNC_SET_VALUE = 3'd5,
        FUNC_CLEAR     = 3'd6
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Controller sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EXWR,
        S_FIN
    } t_state;

    // One input item.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         entry_index;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] out_key;
        logic signed [DATA_W-1:0] out_value;
        logic [IDX_W-1:0]         out_index;
        logic [CNT_W-1:0]         entry_count;
    } t_out_item;

endpackage
`default_nettype wire

>>> hw/rtl/umpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unsorted max-priority table: entry memory
// Simple dual-port synchronous memory, one write and one read port, with a
// registered read.
// ----------------------------------------------------------------------------
module umpt_ram #(
    parameter int WIDTH = umpt_pkg::DATA_W,
    parameter int DEPTH = umpt_pkg::DEF_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/umpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unsorted max-priority table: controller
// Sequencer that runs one item at a time against the key and value memories:
// single writes for insert and set, a linear read scan for extract, peek and
// find, and a write-back of the last entry after an extract.
// ----------------------------------------------------------------------------
module umpt_ctrl #(
    parameter int CAPACITY = umpt_pkg::DEF_CAPACITY
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Item input.
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire umpt_pkg::t_in_item                   i_in_item,
    // Result towards the output register.
    output logic                                      o_res_valid,
    input  wire logic                                 i_res_ready,
    output umpt_pkg::t_out_item                       o_res_item,
    // Key memory.
    output logic                                      o_key_we,
    output logic [$clog2(CAPACITY)-1:0]               o_key_waddr,
    output logic [umpt_pkg::DATA_W-1:0]               o_key_wdata,
    input  wire logic [umpt_pkg::DATA_W-1:0]          i_key_rdata,
    // Value memory.
    output logic                                      o_val_we,
    output logic [$clog2(CAPACITY)-1:0]               o_val_waddr,
    output logic [umpt_pkg::DATA_W-1:0]               o_val_wdata,
    input  wire logic [umpt_pkg::DATA_W-1:0]          i_val_rdata,
    // Shared read address.
    output logic [$clog2(CAPACITY)-1:0]               o_raddr
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > umpt_pkg::IDX_W) ? CW : umpt_pkg::IDX_W;
    localparam int DW    = umpt_pkg::DATA_W;

    umpt_pkg::t_state   r_state, n_state;
    umpt_pkg::t_in_item r_item, n_item;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic [DW-1:0]      r_best_key, n_best_key;
    logic [DW-1:0]      r_best_val, n_best_val;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic               r_found, n_found;
    logic [DW-1:0]      r_last_key, n_last_key;
    logic [DW-1:0]      r_last_val, n_last_val;
    logic [umpt_pkg::STATUS_W-1:0] r_status, n_status;
    logic [DW-1:0]      r_okey, n_okey;
    logic [DW-1:0]      r_oval, n_oval;
    logic [umpt_pkg::IDX_W-1:0]    r_oidx, n_oidx;

    logic          issue;
    logic          in_range;
    logic          is_find;
    logic [AW-1:0] idx_addr;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= umpt_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_found <= n_found;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_best_key <= n_best_key;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_last_key <= n_last_key;
        r_last_val <= n_last_val;
        r_status   <= n_status;
        r_okey     <= n_okey;
        r_oval     <= n_oval;
        r_oidx     <= n_oidx;
    end

    // Decoded item properties.
    assign issue    = (r_addr < r_count);
    assign in_range = (CMP_W'(r_item.entry_index) < CMP_W'(r_count));
    assign is_find  = (r_item.func == umpt_pkg::FUNC_FIND);
    assign idx_addr = AW'(r_item.entry_index);

    // Next state, memory accesses and result.
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_best_key = r_best_key;
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        n_last_key = r_last_key;
        n_last_val = r_last_val;
        n_status   = r_status;
        n_okey     = r_okey;
        n_oval     = r_oval;
        n_oidx     = r_oidx;
        o_key_we    = 1'b0;
        o_val_we    = 1'b0;
        o_key_waddr = r_best_idx;
        o_val_waddr = r_best_idx;
        o_key_wdata = r_last_key;
        o_val_wdata = r_last_val;
        o_raddr     = r_addr[AW-1:0];
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            umpt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = umpt_pkg::S_EXEC;
                end
            end

            umpt_pkg::S_EXEC: begin
                n_status = umpt_pkg::ST_OK;
                n_okey   = '0;
                n_oval   = '0;
                n_oidx   = '0;
                n_addr   = '0;
                n_pend   = 1'b0;
                n_found  = 1'b0;
                n_state  = umpt_pkg::S_FIN;
                case (r_item.func)
                    umpt_pkg::FUNC_INSERT: begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = umpt_pkg::ST_FULL;
                        end else begin
                            o_key_we    = 1'b1;
                            o_val_we    = 1'b1;
                            o_key_waddr = r_count[AW-1:0];
                            o_val_waddr = r_count[AW-1:0];
                            o_key_wdata = r_item.key;
                            o_val_wdata = r_item.value;
                            n_oidx      = umpt_pkg::IDX_W'(r_count);
                            n_count     = CW'(r_count + 1'b1);
                        end
                    end
                    umpt_pkg::FUNC_EXTRACT, umpt_pkg::FUNC_PEEK: begin
                        if (r_count == '0) begin
                            n_status = umpt_pkg::ST_NONE;
                        end else begin
                            n_state = umpt_pkg::S_SCAN;
                        end
                    end
                    umpt_pkg::FUNC_FIND: begin
                        n_state = umpt_pkg::S_SCAN;
                    end
                    umpt_pkg::FUNC_SET_KEY: begin
                        n_oidx = r_item.entry_index;
                        if (in_range) begin
                            o_key_we    = 1'b1;
                            o_key_waddr = idx_addr;
                            o_key_wdata = r_item.key;
                        end else begin
                            n_status = umpt_pkg::ST_RANGE;
                        end
                    end
                    umpt_pkg::FUNC_SET_VALUE: begin
                        n_oidx = r_item.entry_index;
                        if (in_range) begin
                            o_val_we    = 1'b1;
                            o_val_waddr = idx_addr;
                            o_val_wdata = r_item.value;
                        end else begin
                            n_status = umpt_pkg::ST_RANGE;
                        end
                    end
                    umpt_pkg::FUNC_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end

            umpt_pkg::S_SCAN: begin
                // Issue one read a cycle; its data is examined in the next cycle.
                if (issue) begin
                    n_addr = CW'(r_addr + 1'b1);
                    n_pend = 1'b1;
                    n_pidx = r_addr[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pend) begin
                    // The final entry read is the last slot, kept for extract.
                    n_last_key = i_key_rdata;
                    n_last_val = i_val_rdata;
                    if (is_find) begin
                        if (!r_found && (i_val_rdata == r_item.value)) begin
                            n_found    = 1'b1;
                            n_best_key = i_key_rdata;
                            n_best_val = i_val_rdata;
                            n_best_idx = r_pidx;
                        end
                    end else if ((r_pidx == '0) ||
                                 ($signed(i_key_rdata) > $signed(r_best_key))) begin
                        n_best_key = i_key_rdata;
                        n_best_val = i_val_rdata;
                        n_best_idx = r_pidx;
                    end
                end

                // All entries issued and examined.
                if (!issue && !r_pend) begin
                    n_state = umpt_pkg::S_FIN;
                    if (is_find && !r_found) begin
                        n_status = umpt_pkg::ST_NONE;
                    end else begin
                        n_okey = r_best_key;
                        n_oval = r_best_val;
                        n_oidx = umpt_pkg::IDX_W'(r_best_idx);
                    end
                    if (r_item.func == umpt_pkg::FUNC_EXTRACT) begin
                        n_state = umpt_pkg::S_EXWR;
                    end
                end
            end

            umpt_pkg::S_EXWR: begin
                // Move the last entry into the freed slot.
                o_key_we = 1'b1;
                o_val_we = 1'b1;
                n_count  = CW'(r_count - 1'b1);
                n_state  = umpt_pkg::S_FIN;
            end

            umpt_pkg::S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = umpt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = umpt_pkg::S_IDLE;
            end
        endcase
    end

    // Result item; the count is already the one after the operation.
    always_comb begin
        o_res_item.status      = r_status;
        o_res_item.out_key     = r_okey;
        o_res_item.out_value   = r_oval;
        o_res_item.out_index   = r_oidx;
        o_res_item.entry_count = umpt_pkg::CNT_W'(r_count);
    end

endmodule
`default_nettype wire

>>> hw/rtl/unsorted_max_priority_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unsorted max-priority table
// Key/value table in insertion order used as a max-priority queue, with the
// entries held in two synchronous memories and a registered result output.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Insert, set key, set value, clear, the
// unused code, and peek or extract on an empty table go from the execute
// step straight to the result. Extract, peek and find otherwise scan the
// held entries through the memory read port, one entry a cycle, and a find
// on an empty table scans none; extract then writes the last entry back
// into the freed slot. The next item is accepted in the cycle after the
// controller has handed its result on, even if the output register is
// still waiting; while both hold a result the input stays closed.
// ----------------------------------------------------------------------------
module unsorted_max_priority_table #(
    parameter int CAPACITY = umpt_pkg::DEF_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire umpt_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output umpt_pkg::t_out_item      o_out_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = umpt_pkg::DATA_W;

    logic                w_res_valid;
    logic                w_res_ready;
    umpt_pkg::t_out_item w_res_item;
    logic                w_key_we;
    logic [AW-1:0]       w_key_waddr;
    logic [DW-1:0]       w_key_wdata;
    logic [DW-1:0]       w_key_rdata;
    logic                w_val_we;
    logic [AW-1:0]       w_val_waddr;
    logic [DW-1:0]       w_val_wdata;
    logic [DW-1:0]       w_val_rdata;
    logic [AW-1:0]       w_raddr;

    logic                r_out_valid;
    umpt_pkg::t_out_item r_out_item;

    // Sequencer.
    umpt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res_item  (w_res_item),
        .o_key_we    (w_key_we),
        .o_key_waddr (w_key_waddr),
        .o_key_wdata (w_key_wdata),
        .i_key_rdata (w_key_rdata),
        .o_val_we    (w_val_we),
        .o_val_waddr (w_val_waddr),
        .o_val_wdata (w_val_wdata),
        .i_val_rdata (w_val_rdata),
        .o_raddr     (w_raddr)
    );

    // Key memory.
    umpt_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (w_key_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_key_rdata)
    );

    // Value memory.
    umpt_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_val_waddr),
        .i_wdata (w_val_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_val_rdata)
    );

    // Output register: takes a result whenever it is empty or being emptied.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_item <= w_res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // The controller never takes an item while it is presenting a result.
    a_accept_vs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && w_res_valid))
        else $error("item accepted while a result was pending");

    // A result handed on appears at the output in the next cycle.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_out_valid)
        else $error("handed-on result did not reach the output register");

    // A full status is only reported with the table at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == umpt_pkg::ST_FULL)) |->
        (o_out_item.entry_count == umpt_pkg::CNT_W'(CAPACITY)))
        else $error("full status with the table below capacity");
`endif

endmodule
`default_nettype wire
